@@ hw/rtl/assert_macros.svh @@
// assertion macros used by the port-level checker
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// clocked implication with reset disable
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// next-cycle implication with reset disable
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`endif

@@ hw/rtl/apid_pkg.sv @@
// package for the adaptive pid controller: constants, commands, status
// no dependencies
`default_nettype none
package apid_pkg;
  localparam int DataWidth = 32;
  localparam int FracBits  = 16;
  localparam int CfgIdxW   = 3;

  localparam logic [CfgIdxW-1:0] RegGoal   = 3'd0;
  localparam logic [CfgIdxW-1:0] RegStep   = 3'd1;
  localparam logic [CfgIdxW-1:0] RegKp     = 3'd2;
  localparam logic [CfgIdxW-1:0] RegKi     = 3'd3;
  localparam logic [CfgIdxW-1:0] RegKd     = 3'd4;
  localparam logic [CfgIdxW-1:0] RegDead   = 3'd5;
  localparam logic [CfgIdxW-1:0] RegBias   = 3'd6;
  localparam logic [CfgIdxW-1:0] RegIntLim = 3'd7;

  localparam logic [1:0] StatNormal   = 2'd0;
  localparam logic [1:0] StatDeadband = 2'd1;
  localparam logic [1:0] StatBadStep  = 2'd2;

  // datapath micro operations
  typedef enum logic [4:0] {
    OP_NONE, OP_ERR, OP_HALF, OP_INTMUL, OP_INTADD, OP_DIVINIT, OP_DIVSTEP, OP_DIVDONE,
    OP_PMUL, OP_IMUL, OP_DMUL, OP_BIAS, OP_MEAN1, OP_MEAN2, OP_SPR1, OP_SPR2, OP_SPR3,
    OP_OVR, OP_KI, OP_KPD1, OP_KPD2, OP_TALLY, OP_KPD3, OP_CLAMP
  } op_e;

  typedef struct packed {
    op_e  op;
  } cmd_t;

  typedef struct packed {
    logic skip;      // deadband or bad step
    logic div_last;
    logic ovr_hi;
  } sts_t;
endpackage
`default_nettype wire

@@ hw/rtl/apid_ctrl.sv @@
// controller sequencer for the adaptive pid controller
// depends on apid_pkg
`default_nettype none
module apid_ctrl import apid_pkg::*; (
  input  wire  logic clk_i,
  input  wire  logic rst_ni,
  input  wire  logic start_i,
  input  wire  sts_t sts_i,
  input  wire  logic out_free_i,
  output cmd_t       cmd_o,
  output logic       busy_o,
  output logic       done_o
);
  localparam logic [4:0] S_IDLE = 5'd0, S_HALF = 5'd1, S_IMUL = 5'd2, S_IADD = 5'd3,
    S_DINIT = 5'd4, S_DSTEP = 5'd5, S_DDONE = 5'd6, S_P = 5'd7, S_I = 5'd8,
    S_D = 5'd9, S_B = 5'd10, S_M1 = 5'd11, S_M2 = 5'd12, S_S1 = 5'd13, S_S2 = 5'd14,
    S_S3 = 5'd15, S_OV = 5'd16, S_KI = 5'd17, S_K1 = 5'd18, S_K2 = 5'd19,
    S_T = 5'd20, S_K3 = 5'd21, S_CL = 5'd22, S_OUT = 5'd23, S_ERR = 5'd24;
  logic [4:0] state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o.op = OP_NONE;
    done_o = 1'b0;
    unique case (state_q)
      S_IDLE: if (start_i) begin
        cmd_o.op = OP_ERR; state_d = S_ERR;
      end
      S_ERR:   state_d = sts_i.skip ? S_OUT : S_HALF;
      S_HALF:  begin cmd_o.op = OP_HALF; state_d = S_IMUL; end
      S_IMUL:  begin cmd_o.op = OP_INTMUL; state_d = S_IADD; end
      S_IADD:  begin cmd_o.op = OP_INTADD; state_d = S_DINIT; end
      S_DINIT: begin cmd_o.op = OP_DIVINIT; state_d = S_DSTEP; end
      S_DSTEP: begin
        cmd_o.op = OP_DIVSTEP;
        if (sts_i.div_last) state_d = S_DDONE;
      end
      S_DDONE: begin cmd_o.op = OP_DIVDONE; state_d = S_P; end
      S_P:  begin cmd_o.op = OP_PMUL; state_d = S_I; end
      S_I:  begin cmd_o.op = OP_IMUL; state_d = S_D; end
      S_D:  begin cmd_o.op = OP_DMUL; state_d = S_B; end
      S_B:  begin cmd_o.op = OP_BIAS; state_d = S_M1; end
      S_M1: begin cmd_o.op = OP_MEAN1; state_d = S_M2; end
      S_M2: begin cmd_o.op = OP_MEAN2; state_d = S_S1; end
      S_S1: begin cmd_o.op = OP_SPR1; state_d = S_S2; end
      S_S2: begin cmd_o.op = OP_SPR2; state_d = S_S3; end
      S_S3: begin cmd_o.op = OP_SPR3; state_d = S_OV; end
      S_OV: begin cmd_o.op = OP_OVR; state_d = S_KI; end
      S_KI: begin cmd_o.op = OP_KI; state_d = S_K1; end
      S_K1: begin cmd_o.op = OP_KPD1; state_d = S_K2; end
      S_K2: begin cmd_o.op = OP_KPD2; state_d = S_T; end
      S_T:  begin cmd_o.op = OP_TALLY; state_d = sts_i.ovr_hi ? S_K3 : S_CL; end
      S_K3: begin cmd_o.op = OP_KPD3; state_d = S_CL; end
      S_CL: begin cmd_o.op = OP_CLAMP; state_d = S_OUT; end
      S_OUT: if (out_free_i) begin
        done_o = 1'b1; state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign busy_o = (state_q != S_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= S_IDLE;
    else         state_q <= state_d;
  end
endmodule
`default_nettype wire

@@ hw/rtl/apid_datapath.sv @@
// datapath for the adaptive pid controller: registers, two multipliers, serial divider
// depends on apid_pkg
`default_nettype none
module apid_datapath import apid_pkg::*; #(
  parameter int DW = DataWidth,
  parameter int FB = FracBits
) (
  input  wire  logic          clk_i,
  input  wire  logic          rst_ni,
  input  wire  logic          cfg_we_i,
  input  wire  logic [CfgIdxW-1:0] cfg_idx_i,
  input  wire  logic [DW-1:0] cfg_data_i,
  input  wire  logic [DW-1:0] reading_i,
  input  wire  cmd_t          cmd_i,
  output sts_t                sts_o,
  output logic [DW-1:0]       drive_o,
  output logic [1:0]          status_o
);
  typedef logic signed [DW-1:0] w_t;
  localparam w_t VMAX = w_t'({1'b0, {(DW-1){1'b1}}});
  localparam w_t VMIN = w_t'({1'b1, {(DW-1){1'b0}}});
  localparam int NW = DW + FB;           // dividend width
  localparam int CW = $clog2(NW + 2);

  w_t goal_q, step_q, bias_q, kp_q, ki_q, kd_q, dead_q, lim_q;
  w_t integ_q, prev_q, mean_q, spr_q, sgn_q, tally_q;
  w_t e_q, half_q, acc_q, deriv_q, tmp_q, o_q;
  logic [1:0] stat_q;
  logic neg_q;
  logic [NW-1:0] num_q, quo_q;
  logic [DW:0] rem_q;
  logic [CW-1:0] cnt_q;

  // Q16.16 constant rescaled to frac bits by truncation, saturated
  function automatic w_t qcv(input logic [31:0] v16);
    logic [95:0] r;
    if (FB >= 16) r = 96'(v16) << (FB - 16);
    else          r = 96'(v16) >> (16 - FB);
    if (r > 96'(VMAX)) r = 96'(VMAX);
    return w_t'(r[DW-1:0]);
  endfunction

  // saturating add
  function automatic w_t sadd(input w_t a, input w_t b);
    logic signed [DW:0] s;
    s = $signed({a[DW-1], a}) + $signed({b[DW-1], b});
    if (s > $signed({VMAX[DW-1], VMAX})) return VMAX;
    if (s < $signed({VMIN[DW-1], VMIN})) return VMIN;
    return s[DW-1:0];
  endfunction

  function automatic w_t clampv(input w_t v, input w_t lo, input w_t hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic w_t sat_mag(input logic neg, input logic [2*DW-1:0] m);
    if (neg) begin
      if (m > {{DW{1'b0}}, 1'b1, {(DW-1){1'b0}}}) return VMIN;
      return w_t'(-$signed({1'b0, m}));
    end
    if (m > {{(DW+1){1'b0}}, {(DW-1){1'b1}}}) return VMAX;
    return m[DW-1:0];
  endfunction

  // shared multiplier: truncated magnitude product shifted by frac bits
  w_t ma, mb, mres;
  logic [DW-1:0] mam, mbm;
  logic [2*DW-1:0] mprod;
  always_comb begin
    mam = ma[DW-1] ? DW'(-ma) : ma;
    mbm = mb[DW-1] ? DW'(-mb) : mb;
    mprod = (2*DW)'(mam) * (2*DW)'(mbm);
    mres = sat_mag(ma[DW-1] ^ mb[DW-1], mprod >> FB);
  end

  w_t a_c, up_c, dn_c, keep_c, dev_c;
  logic [DW:0] ediff;
  logic [DW:0] rsh;
  logic rfit;
  always_comb begin
    a_c = qcv(32'd6554);
    up_c = qcv(32'd66191);
    dn_c = qcv(32'd64881);
    keep_c = qcv(32'd65536) - a_c;
    dev_c = sadd(e_q, -mean_q);
    if (mean_q == VMIN) dev_c = sadd(e_q, VMAX);
    ma = '0; mb = '0;
    case (cmd_i.op)
      OP_INTMUL: begin ma = step_q; mb = half_q; end
      OP_PMUL:   begin ma = kp_q; mb = e_q; end
      OP_IMUL:   begin ma = ki_q; mb = integ_q; end
      OP_DMUL:   begin ma = kd_q; mb = deriv_q; end
      OP_MEAN1:  begin ma = keep_c; mb = mean_q; end
      OP_MEAN2:  begin ma = a_c; mb = e_q; end
      OP_SPR1:   begin ma = keep_c; mb = spr_q; end
      OP_SPR2:   begin ma = a_c; mb = dev_c; end
      OP_SPR3:   begin ma = tmp_q; mb = dev_c; end
      OP_KI:     begin ma = ki_q; mb = ((mean_q[DW-1] ? -mean_q : mean_q) > qcv(32'd32768)
                   || mean_q == VMIN) ? up_c : dn_c; end
      OP_KPD1:   begin ma = kp_q; mb = (spr_q > qcv(32'd65536)) ? dn_c : up_c; end
      OP_KPD2:   begin ma = kd_q; mb = (spr_q > qcv(32'd65536)) ? up_c : dn_c; end
      OP_TALLY:  begin ma = tally_q;
                   mb = (tally_q > qcv(32'd196608)) ? qcv(32'd32768) : qcv(32'd58982); end
      OP_KPD3:   begin ma = kp_q; mb = dn_c; end
      default: ;
    endcase
    ediff = neg_q ? ({prev_q[DW-1], prev_q} - {e_q[DW-1], e_q})
                  : ({e_q[DW-1], e_q} - {prev_q[DW-1], prev_q});
    rsh = {rem_q[DW-1:0], num_q[NW-1]};
    rfit = rem_q[DW] || (rsh >= {1'b0, step_q});
  end

  // second multiply of the overshoot branch: kd times step up, staged in the tally cycle
  w_t kd_up_q;
  w_t kd_up_c;
  logic [2*DW-1:0] kd_prod;
  always_comb begin
    kd_prod = (2*DW)'(kd_q[DW-1] ? DW'(-kd_q) : kd_q) * (2*DW)'(up_c);
    kd_up_c = sat_mag(kd_q[DW-1], kd_prod >> FB);
  end
  always_ff @(posedge clk_i) begin
    if (cmd_i.op == OP_TALLY) kd_up_q <= kd_up_c;
  end

  assign sts_o.div_last = (cnt_q == CW'(1));
  assign sts_o.ovr_hi = (tally_q > qcv(32'd196608));
  assign sts_o.skip = (stat_q != StatNormal);
  assign drive_o = o_q;
  assign status_o = stat_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      goal_q <= '0; step_q <= '0; bias_q <= '0; dead_q <= '0;
      kp_q <= (DW > 17) ? w_t'(65536) : VMAX; ki_q <= '0; kd_q <= '0;
      lim_q <= (DW > 31) ? w_t'(32'h7fffffff) : VMAX;
      integ_q <= '0; prev_q <= '0; mean_q <= '0; spr_q <= '0; sgn_q <= '0; tally_q <= '0;
      stat_q <= StatNormal;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        RegGoal:   begin goal_q <= cfg_data_i; integ_q <= '0; prev_q <= '0; end
        RegStep:   step_q <= cfg_data_i;
        RegKp:     kp_q <= w_t'({1'b0, cfg_data_i[DW-2:0]});
        RegKi:     ki_q <= w_t'({1'b0, cfg_data_i[DW-2:0]});
        RegKd:     kd_q <= w_t'({1'b0, cfg_data_i[DW-2:0]});
        RegDead:   dead_q <= w_t'({1'b0, cfg_data_i[DW-2:0]});
        RegBias:   bias_q <= cfg_data_i;
        RegIntLim: lim_q <= w_t'({1'b0, cfg_data_i[DW-2:0]});
        default: ;
      endcase
    end else begin
      case (cmd_i.op)
        OP_ERR: begin
          logic signed [DW:0] ev;
          logic [DW:0] em;
          w_t es;
          ev = $signed({goal_q[DW-1], goal_q}) - $signed({reading_i[DW-1], reading_i});
          es = (ev > $signed({VMAX[DW-1], VMAX})) ? VMAX
               : (ev < $signed({VMIN[DW-1], VMIN})) ? VMIN : ev[DW-1:0];
          em = es[DW-1] ? (DW+1)'(-{es[DW-1], es}) : {1'b0, es};
          e_q <= es;
          o_q <= bias_q;
          if (em <= {1'b0, dead_q}) stat_q <= StatDeadband;
          else if (step_q[DW-1] || step_q == '0) stat_q <= StatBadStep;
          else stat_q <= StatNormal;
        end
        OP_HALF: half_q <= (e_q >>> 1) + (prev_q >>> 1) + w_t'(e_q[0] & prev_q[0]);
        OP_INTMUL: acc_q <= mres;
        OP_INTADD: integ_q <= clampv(sadd(integ_q, acc_q), -lim_q, lim_q);
        OP_DIVINIT: begin
          neg_q <= (e_q < prev_q);
          cnt_q <= CW'(NW + 1);
          rem_q <= '0;
          quo_q <= '0;
        end
        OP_DIVSTEP: begin
          // first cycle loads the dividend, then one quotient bit per cycle
          if (cnt_q == CW'(NW + 1)) begin
            num_q <= NW'(ediff) << FB;
            cnt_q <= CW'(NW);
          end else begin
            rem_q <= rfit ? (rsh - {1'b0, step_q}) : rsh;
            quo_q <= {quo_q[NW-2:0], rfit};
            num_q <= num_q << 1;
            cnt_q <= cnt_q - CW'(1);
          end
        end
        OP_DIVDONE: deriv_q <= sat_mag(neg_q, (2*DW)'(quo_q));
        OP_PMUL: acc_q <= mres;
        OP_IMUL: acc_q <= sadd(acc_q, mres);
        OP_DMUL: acc_q <= sadd(acc_q, mres);
        OP_BIAS: begin o_q <= sadd(acc_q, bias_q); prev_q <= e_q; end
        OP_MEAN1: tmp_q <= mres;
        OP_MEAN2: mean_q <= sadd(tmp_q, mres);
        OP_SPR1: acc_q <= mres;
        OP_SPR2: tmp_q <= mres;
        OP_SPR3: spr_q <= sadd(acc_q, mres);
        OP_OVR: begin
          if ((!e_q[DW-1] && e_q != '0 && sgn_q[DW-1]) ||
              (e_q[DW-1] && !sgn_q[DW-1] && sgn_q != '0))
            tally_q <= sadd(tally_q, qcv(32'd65536));
          sgn_q <= e_q;
        end
        OP_KI:   ki_q <= mres;
        OP_KPD1: kp_q <= mres;
        OP_KPD2: kd_q <= mres;
        OP_TALLY: tally_q <= mres;
        OP_KPD3: begin kp_q <= mres; kd_q <= kd_up_q; end
        OP_CLAMP: begin
          kp_q <= clampv(kp_q, qcv(32'd6554), qcv(32'd655360));
          ki_q <= clampv(ki_q, '0, qcv(32'd327680));
          kd_q <= clampv(kd_q, '0, qcv(32'd327680));
        end
        default: ;
      endcase
    end
  end
endmodule
`default_nettype wire

@@ hw/rtl/adaptive_pid_controller.sv @@
// adaptive pid controller: one drive value per reading, one transaction in flight at a time
// result valid after the sequencer steps, the overshoot branch adding one more gain update and
// the bit-serial derivative divider taking the longest; deadband or bad step skips to the output
// next input taken in the same cycle as the result appears; a stalled output delays this,
// since a held result keeps the controller waiting
// reset is asynchronous active low and restores state, configuration, gains and adaptation
`default_nettype none
module adaptive_pid_controller import apid_pkg::*; #(
  parameter int DATA_WIDTH = DataWidth,
  parameter int FRAC_BITS = FracBits
) (
  input  wire  logic clk_i,
  input  wire  logic rst_ni,
  input  wire  logic cfg_we_i,
  input  wire  logic [CfgIdxW-1:0] cfg_idx_i,
  input  wire  logic [DATA_WIDTH-1:0] cfg_data_i,
  input  wire  logic in_valid_i,
  output logic       in_stall_o,
  input  wire  logic [DATA_WIDTH-1:0] reading_i,
  output logic       out_valid_o,
  input  wire  logic out_stall_i,
  output logic [DATA_WIDTH-1:0] drive_o,
  output logic [1:0] status_o
);
  cmd_t cmd;
  sts_t sts;
  logic busy, done, start;
  logic ov_q;
  logic [DATA_WIDTH-1:0] drv_q, drv_c;
  logic [1:0] st_q, st_c;

  assign in_stall_o = busy;
  assign start = in_valid_i && !busy;

  apid_ctrl u_ctrl (
    .clk_i, .rst_ni, .start_i(start), .sts_i(sts), .out_free_i(!ov_q || !out_stall_i),
    .cmd_o(cmd), .busy_o(busy), .done_o(done)
  );

  apid_datapath #(.DW(DATA_WIDTH), .FB(FRAC_BITS)) u_dp (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i, .reading_i,
    .cmd_i(cmd), .sts_o(sts), .drive_o(drv_c), .status_o(st_c)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) ov_q <= 1'b0;
    else if (done) ov_q <= 1'b1;
    else if (!out_stall_i) ov_q <= 1'b0;
  end
  always_ff @(posedge clk_i) begin
    if (done) begin drv_q <= drv_c; st_q <= st_c; end
  end
  assign out_valid_o = ov_q;
  assign drive_o = drv_q;
  assign status_o = st_q;
endmodule
`default_nettype wire

@@ hw/rtl/apid_checker.sv @@
// port-level checker for the adaptive pid controller, bound to the top level
// depends on assert_macros.svh
`default_nettype none
`include "assert_macros.svh"
module apid_checker (
  input wire logic clk_i,
  input wire logic rst_ni,
  input wire logic in_valid_i,
  input wire logic in_stall_o,
  input wire logic out_valid_o,
  input wire logic out_stall_i,
  input wire logic [1:0] status_o
);
  `ASSERT_NEXT(a_busy_after_accept, clk_i, rst_ni, in_valid_i && !in_stall_o, in_stall_o,
    "input not stalled after a transaction")
  `ASSERT_IMPL(a_status_legal, clk_i, rst_ni, out_valid_o, status_o != 2'd3,
    "illegal status code")
  `ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o,
    "stalled result dropped")
endmodule
bind adaptive_pid_controller apid_checker u_apid_checker (.*);
`default_nettype wire
